// ===== hdl/srtfl_pkg.sv =====
// ----------------------------------------------------------------------------
// srtfl_pkg
// shared types and constants of the sorted range table floor lookup unit
// ----------------------------------------------------------------------------
`default_nettype none

package srtfl_pkg;

   localparam int TABLE_DEPTH       = 1024;
   localparam int ADDR_BITS         = $clog2(TABLE_DEPTH);
   localparam int COUNT_BITS        = $clog2(TABLE_DEPTH + 1);
   localparam int HALF_BITS         = 32;
   localparam int KEY_BITS          = 2 * HALF_BITS;
   localparam int LINE_BITS         = 32;
   localparam int HANDLE_BITS       = 16;
   localparam int FIELD_HANDLE_BITS = 16;
   localparam int IDX_BITS          = 10;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   typedef struct packed {
      logic [KEY_BITS-1:0]    key;
      logic [LINE_BITS-1:0]   line;
      logic [HANDLE_BITS-1:0] handle;
   } entry_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      entry_type            wr_data;
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic                         found;
      logic [IDX_BITS-1:0]          entry_index;
      logic [LINE_BITS-1:0]         found_line;
      logic [FIELD_HANDLE_BITS-1:0] found_handle;
      logic                         table_full;
   } res_type;

endpackage

`default_nettype wire

// ===== hdl/srtfl_channels.sv =====
// ----------------------------------------------------------------------------
// srtfl channels
// valid/ready channel interfaces for requests and responses
// ----------------------------------------------------------------------------
`default_nettype none

interface srtfl_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    mode;
   logic [srtfl_pkg::HALF_BITS-1:0]         key_high;
   logic [srtfl_pkg::HALF_BITS-1:0]         key_low;
   logic [srtfl_pkg::LINE_BITS-1:0]         line_number;
   logic [srtfl_pkg::FIELD_HANDLE_BITS-1:0] symbol_handle;

   modport source (output valid, mode, key_high, key_low, line_number, symbol_handle,
                   input ready);
   modport sink (input valid, mode, key_high, key_low, line_number, symbol_handle,
                 output ready);
endinterface

interface srtfl_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    found;
   logic [srtfl_pkg::IDX_BITS-1:0]          entry_index;
   logic [srtfl_pkg::LINE_BITS-1:0]         found_line;
   logic [srtfl_pkg::FIELD_HANDLE_BITS-1:0] found_handle;
   logic                                    table_full;

   modport source (output valid, found, entry_index, found_line, found_handle, table_full,
                   input ready);
   modport sink (input valid, found, entry_index, found_line, found_handle, table_full,
                 output ready);
endinterface

`default_nettype wire

// ===== hdl/srtfl_store.sv =====
// ----------------------------------------------------------------------------
// srtfl_store
// entry memory: one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module srtfl_store (
   input  wire                     clock,
   input  srtfl_pkg::mem_req_type  mem_req,
   output srtfl_pkg::entry_type    rd_data
);

   srtfl_pkg::entry_type mem_ff [srtfl_pkg::TABLE_DEPTH];
   srtfl_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/srtfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// srtfl_ctrl
// sequencer: binary search with one shared key compare, entry shift, fetch
// ----------------------------------------------------------------------------
`default_nettype none

module srtfl_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   srtfl_req_if.sink              req_ch,
   input  srtfl_pkg::entry_type   rd_data,
   output srtfl_pkg::mem_req_type mem_req,
   input  wire                    out_free,
   output logic                   res_valid,
   output srtfl_pkg::res_type     res
);

   typedef enum logic [7:0] {
      ST_IDLE       = 8'b0000_0001,
      ST_SEARCH_RD  = 8'b0000_0010,
      ST_SEARCH_CMP = 8'b0000_0100,
      ST_FETCH      = 8'b0000_1000,
      ST_SHIFT_RD   = 8'b0001_0000,
      ST_SHIFT_WR   = 8'b0010_0000,
      ST_PLACE      = 8'b0100_0000,
      ST_REPLY      = 8'b1000_0000
   } state_type;

   localparam int CB = srtfl_pkg::COUNT_BITS;
   localparam int AB = srtfl_pkg::ADDR_BITS;

   state_type                               state_ff, state_in;
   logic [CB-1:0]                           count_ff, count_in;
   logic [CB-1:0]                           lo_ff, lo_in;
   logic [CB-1:0]                           hi_ff, hi_in;
   logic [CB-1:0]                           ptr_ff, ptr_in;
   logic                                    mode_ff, mode_in;
   logic [srtfl_pkg::KEY_BITS-1:0]          key_ff, key_in;
   logic [srtfl_pkg::LINE_BITS-1:0]         line_ff, line_in;
   logic [srtfl_pkg::HANDLE_BITS-1:0]       handle_ff, handle_in;
   srtfl_pkg::res_type                      res_ff, res_in;
   logic [CB-1:0]                           mid;
   logic [CB-1:0]                           lo_dec;
   logic [CB-1:0]                           ptr_dec;

   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lo_dec  = lo_ff - CB'(1);
   assign ptr_dec = ptr_ff - CB'(1);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      ptr_in    = ptr_ff;
      mode_in   = mode_ff;
      key_in    = key_ff;
      line_in   = line_ff;
      handle_in = handle_ff;
      res_in    = res_ff;
      mem_req   = '0;
      res_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               mode_in   = req_ch.mode;
               key_in    = {req_ch.key_high, req_ch.key_low};
               line_in   = req_ch.line_number;
               handle_in = srtfl_pkg::HANDLE_BITS'(req_ch.symbol_handle);
               lo_in     = '0;
               hi_in     = count_ff;
               res_in    = '0;
               if (req_ch.mode == srtfl_pkg::MODE_INSERT &&
                   count_ff == CB'(srtfl_pkg::TABLE_DEPTH)) begin
                  res_in.table_full = 1'b1;
                  state_in          = ST_REPLY;
               end else begin
                  state_in = ST_SEARCH_RD;
               end
            end
         end
         ST_SEARCH_RD: begin
            if (lo_ff < hi_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = mid[AB-1:0];
               state_in        = ST_SEARCH_CMP;
            end else if (mode_ff == srtfl_pkg::MODE_LOOKUP) begin
               if (lo_ff == '0) begin
                  state_in = ST_REPLY;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = lo_dec[AB-1:0];
                  state_in        = ST_FETCH;
               end
            end else begin
               ptr_in   = count_ff;
               state_in = ST_SHIFT_RD;
            end
         end
         ST_SEARCH_CMP: begin
            if (rd_data.key <= key_ff) begin
               lo_in = mid + CB'(1);
            end else begin
               hi_in = mid;
            end
            state_in = ST_SEARCH_RD;
         end
         ST_FETCH: begin
            res_in.found        = 1'b1;
            res_in.entry_index  = srtfl_pkg::IDX_BITS'(lo_dec);
            res_in.found_line   = rd_data.line;
            res_in.found_handle = srtfl_pkg::FIELD_HANDLE_BITS'(rd_data.handle);
            state_in            = ST_REPLY;
         end
         ST_SHIFT_RD: begin
            if (ptr_ff == lo_ff) begin
               state_in = ST_PLACE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ptr_dec[AB-1:0];
               state_in        = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ptr_ff[AB-1:0];
            mem_req.wr_data = rd_data;
            ptr_in          = ptr_dec;
            state_in        = ST_SHIFT_RD;
         end
         ST_PLACE: begin
            mem_req.wr_en          = 1'b1;
            mem_req.wr_addr        = lo_ff[AB-1:0];
            mem_req.wr_data.key    = key_ff;
            mem_req.wr_data.line   = line_ff;
            mem_req.wr_data.handle = handle_ff;
            count_in               = count_ff + CB'(1);
            res_in.entry_index     = srtfl_pkg::IDX_BITS'(lo_ff);
            state_in               = ST_REPLY;
         end
         ST_REPLY: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      ptr_ff    <= ptr_in;
      mode_ff   <= mode_in;
      key_ff    <= key_in;
      line_ff   <= line_in;
      handle_ff <= handle_in;
      res_ff    <= res_in;
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign res          = res_ff;

endmodule

`default_nettype wire

// ===== hdl/sorted_range_table_floor_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_range_table_floor_lookup_unit
// sorted 64-bit key table with ordered insert and floor lookup
// ----------------------------------------------------------------------------
// Entries are kept in key order in a single memory with one write port and a
// registered read port. Every search step reads one entry and compares it
// with the request key in the one shared 64-bit comparator. A lookup ends by
// fetching the last entry whose key is not above the request key, if any. An
// insert searches in the same way, then moves each entry above the insert
// point up by one to make room and places the new entry; an insert into a
// full table skips the search and offers its result with table_full set.
// One request is in work at a time; the next request transfer can happen as
// soon as the previous result sits in the output register, even if it has
// not been taken yet.
`default_nettype none

module sorted_range_table_floor_lookup_unit (
   input  wire          clock,
   input  wire          reset,
   srtfl_req_if.sink    req_ch,
   srtfl_rsp_if.source  rsp_ch
);

   srtfl_pkg::mem_req_type mem_req;
   srtfl_pkg::entry_type   rd_data;
   srtfl_pkg::res_type     res;
   srtfl_pkg::res_type     rsp_data_ff;
   logic                   res_valid;
   logic                   out_free;
   logic                   rsp_valid_ff;

   srtfl_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   srtfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rd_data   (rd_data),
      .mem_req   (mem_req),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res)
   );

   // output register
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.found        = rsp_data_ff.found;
   assign rsp_ch.entry_index  = rsp_data_ff.entry_index;
   assign rsp_ch.found_line   = rsp_data_ff.found_line;
   assign rsp_ch.found_handle = rsp_data_ff.found_handle;
   assign rsp_ch.table_full   = rsp_data_ff.table_full;

endmodule

`default_nettype wire
